@@ design/dtid_pkg.sv @@
// shared types and constants for the depth to inverse depth cloud unit
// no dependencies; used by every module of the block except dtid_table
`default_nettype none

package dtid_pkg;

  // field widths
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned PIX_W    = 11;
  localparam int unsigned TABLE_W  = 24;
  localparam int unsigned RECIP_W  = 24;
  localparam int unsigned CENTRE_W = 16;
  localparam int unsigned RES_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // signed pixel offset from the principal point, Q12.4
  localparam int unsigned DIFF_W = 17;
  // diff times reciprocal, signed Q.28
  localparam int unsigned PROD_W = 41;

  // quotient bits produced by the divider; larger quotients saturate
  localparam int unsigned Q_W = 31;
  // one set-up stage plus one stage per quotient bit
  localparam int unsigned RECIP_STAGES = Q_W + 1;
  // accept stage, divider, multiply stage, output register
  localparam int unsigned PIPE_STAGES = RECIP_STAGES + 3;

  // top bits of the numerator 2^36 + t/2, above the quotient bits
  localparam logic [5:0] NUM_TOP = 6'd32;

  localparam logic [RAW_W-1:0]        NO_READING_CODE = 16'd2047;
  localparam logic signed [RES_W-1:0] INVALID_Q20     = -32'sd1048576000;
  localparam logic signed [RES_W-1:0] S32_MAX         = 32'sh7fff_ffff;
  localparam logic signed [RES_W-1:0] S32_MIN         = 32'sh8000_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X_RECIP = 2'd0,
    REG_FOCAL_Y_RECIP = 2'd1,
    REG_CENTRE_X      = 2'd2,
    REG_CENTRE_Y      = 2'd3
  } cfg_reg_t;

  // per-pixel data carried alongside the divider
  typedef struct packed {
    logic                     no_reading;
    logic signed [DIFF_W-1:0] diff_u;
    logic signed [DIFF_W-1:0] diff_v;
  } side_t;

  // divider result handed to the normalising stages
  typedef struct packed {
    logic           sat;
    logic [Q_W-1:0] q;
    side_t          side;
  } recip_res_t;

endpackage

`default_nettype wire

@@ design/dtid_table.sv @@
// raw-to-metric depth table: one write port, one registered read port
// no package dependencies
`default_nettype none

module dtid_table #(
  parameter int unsigned ENTRIES = 2047,
  parameter int unsigned DATA_W  = 24,
  localparam int unsigned AW     = $clog2(ENTRIES)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered; data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/dtid_recip.sv @@
// pipelined restoring divider for round(2^36 / t), one quotient bit per stage
// depends on dtid_pkg
`default_nettype none

module dtid_recip (
  input  logic                                  clk,
  input  logic [dtid_pkg::RECIP_STAGES-1:0]     en,
  input  logic [dtid_pkg::TABLE_W-1:0]          tword,
  input  logic                                  tword_ok,
  input  dtid_pkg::side_t                       side_in,
  output dtid_pkg::recip_res_t                  res
);

  import dtid_pkg::*;

  logic [TABLE_W-1:0] tdiv [RECIP_STAGES];
  logic [TABLE_W-1:0] rem  [RECIP_STAGES];
  logic [Q_W-1:0]     num  [RECIP_STAGES];
  logic [Q_W-1:0]     quo  [RECIP_STAGES];
  logic               sat  [RECIP_STAGES];
  side_t              side [RECIP_STAGES];
  logic [TABLE_W-1:0] t_eff;

  // entries beyond the table read as zero
  assign t_eff = tword_ok ? tword : '0;

  // set-up: numerator is 2^36 + t/2; its top bits give the first partial
  // remainder, and a quotient of 2^31 or more saturates (zero word too)
  always_ff @(posedge clk) begin
    if (en[0]) begin
      tdiv[0] <= t_eff;
      rem[0]  <= TABLE_W'(NUM_TOP);
      num[0]  <= Q_W'(t_eff[TABLE_W-1:1]);
      quo[0]  <= '0;
      sat[0]  <= (t_eff <= TABLE_W'(NUM_TOP));
      side[0] <= side_in;
    end
  end

  // one trial subtraction per stage
  for (genvar k = 1; k < RECIP_STAGES; k++) begin : g_step
    logic [TABLE_W:0] trial;
    logic [TABLE_W:0] diff;
    logic             ge;

    assign trial = {rem[k-1], num[k-1][Q_W-1]};
    assign diff  = trial - {1'b0, tdiv[k-1]};
    assign ge    = (trial >= {1'b0, tdiv[k-1]});

    always_ff @(posedge clk) begin
      if (en[k]) begin
        tdiv[k] <= tdiv[k-1];
        rem[k]  <= ge ? diff[TABLE_W-1:0] : trial[TABLE_W-1:0];
        num[k]  <= {num[k-1][Q_W-2:0], 1'b0};
        quo[k]  <= {quo[k-1][Q_W-2:0], ge};
        sat[k]  <= sat[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  assign res.sat  = sat[RECIP_STAGES-1];
  assign res.q    = quo[RECIP_STAGES-1];
  assign res.side = side[RECIP_STAGES-1];

endmodule

`default_nettype wire

@@ design/dtid_norm.sv @@
// normalised u/v by reciprocal multiply, rounding, saturation and result format
// depends on dtid_pkg; ends in the output register of the block
`default_nettype none

module dtid_norm (
  input  logic                                clk,
  input  logic [1:0]                          en,
  input  logic [dtid_pkg::RECIP_W-1:0]        focal_x_recip,
  input  logic [dtid_pkg::RECIP_W-1:0]        focal_y_recip,
  input  dtid_pkg::recip_res_t                res_in,
  output logic signed [dtid_pkg::RES_W-1:0]   u_coord,
  output logic signed [dtid_pkg::RES_W-1:0]   v_coord,
  output logic signed [dtid_pkg::RES_W-1:0]   inv_depth,
  output logic                                valid_res
);

  import dtid_pkg::*;

  logic signed [PROD_W-1:0] prod_u;
  logic signed [PROD_W-1:0] prod_v;
  logic [Q_W-1:0]           q;
  logic                     q_sat;
  logic                     no_reading;
  logic signed [PROD_W-1:0] rnd_u;
  logic signed [PROD_W-1:0] rnd_v;
  logic signed [RES_W-1:0]  sat_u;
  logic signed [RES_W-1:0]  sat_v;

  // Q.28 to Q.20, round half up, clamp to 32 bits
  function automatic logic signed [RES_W-1:0] round_sat(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] r;
    r = (p + PROD_W'(128)) >>> 8;
    if (r > PROD_W'(S32_MAX)) begin
      return S32_MAX;
    end else if (r < PROD_W'(S32_MIN)) begin
      return S32_MIN;
    end
    return r[RES_W-1:0];
  endfunction

  // multiply stage
  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_u     <= $signed({{(PROD_W-DIFF_W){res_in.side.diff_u[DIFF_W-1]}},
                             res_in.side.diff_u})
                  * $signed({{(PROD_W-RECIP_W){1'b0}}, focal_x_recip});
      prod_v     <= $signed({{(PROD_W-DIFF_W){res_in.side.diff_v[DIFF_W-1]}},
                             res_in.side.diff_v})
                  * $signed({{(PROD_W-RECIP_W){1'b0}}, focal_y_recip});
      q          <= res_in.q;
      q_sat      <= res_in.sat;
      no_reading <= res_in.side.no_reading;
    end
  end

  assign rnd_u = prod_u;
  assign rnd_v = prod_v;
  assign sat_u = round_sat(rnd_u);
  assign sat_v = round_sat(rnd_v);

  // output register
  always_ff @(posedge clk) begin
    if (en[1]) begin
      if (no_reading) begin
        u_coord   <= INVALID_Q20;
        v_coord   <= INVALID_Q20;
        inv_depth <= INVALID_Q20;
        valid_res <= 1'b0;
      end else begin
        u_coord   <= sat_u;
        v_coord   <= sat_v;
        inv_depth <= q_sat ? S32_MAX : $signed({1'b0, q});
        valid_res <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/depth_to_inverse_depth_cloud_unit.sv @@
// top level of the depth to inverse depth cloud unit
// depends on dtid_pkg, dtid_table, dtid_recip and dtid_norm
`default_nettype none

// Takes one input transaction per clock while input is not refused. A load
// transaction (cmd 0) writes one Q8.16 word into the depth table in its cycle
// and gives no result. A pixel transaction (cmd 1) gives one result, through
// 35 register stages: one for the table read, 32 for the
// divider (a set-up stage and one stage per quotient bit of the inverse
// depth), one for the focal multiply and one for the output register. The
// pipeline closes up bubbles, so input is refused only when all 35 stages
// hold pixels and the output is stalled.
// The table has one write and one read port; a load and a later pixel never
// touch it in the same cycle, so a pixel always sees every earlier load.
// Table entries are not cleared by reset and must be loaded before use.
// Configuration is taken at any time but must only change while idle.
module depth_to_inverse_depth_cloud_unit #(
  parameter int unsigned TABLE_ENTRIES = 2047
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  cmd,
  input  logic [dtid_pkg::RAW_W-1:0]            raw_depth,
  input  logic [dtid_pkg::PIX_W-1:0]            row,
  input  logic [dtid_pkg::PIX_W-1:0]            col,
  input  logic [dtid_pkg::PIX_W-1:0]            table_index,
  input  logic [dtid_pkg::TABLE_W-1:0]          table_value,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [dtid_pkg::RES_W-1:0]     u_coord,
  output logic signed [dtid_pkg::RES_W-1:0]     v_coord,
  output logic signed [dtid_pkg::RES_W-1:0]     inv_depth,
  output logic                                  valid_res,
  // configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dtid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dtid_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import dtid_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned L  = PIPE_STAGES;

  logic [RECIP_W-1:0]  focal_x_recip;
  logic [RECIP_W-1:0]  focal_y_recip;
  logic [CENTRE_W-1:0] centre_x;
  logic [CENTRE_W-1:0] centre_y;

  logic [L:1]          vld;
  logic [L:1]          rdy;
  logic                in_acc;
  logic                pix_acc;
  logic                load_acc;
  logic [RAW_W-1:0]    tidx_ext;
  logic                tidx_ok;
  logic                raw_ok;
  logic                s1_raw_ok;
  side_t               s1_side;
  logic [TABLE_W-1:0]  tword;
  recip_res_t          recip_res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x_recip <= 24'd28926;
      focal_y_recip <= 24'd28926;
      centre_x      <= 16'd5120;
      centre_y      <= 16'd3840;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FOCAL_X_RECIP: focal_x_recip <= cfg_data[RECIP_W-1:0];
        REG_FOCAL_Y_RECIP: focal_y_recip <= cfg_data[RECIP_W-1:0];
        REG_CENTRE_X:      centre_x      <= cfg_data[CENTRE_W-1:0];
        REG_CENTRE_Y:      centre_y      <= cfg_data[CENTRE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage ready: a stage takes a new transaction when it or any later stage
  // has a hole, or the output is being drained
  for (genvar s = 1; s <= L; s++) begin : g_rdy
    assign rdy[s] = out_ready || !(&vld[L:s]);
  end

  assign in_ready = rdy[1];
  assign in_acc   = in_valid && in_ready;
  assign pix_acc  = in_acc && cmd;
  assign load_acc = in_acc && !cmd;

  // stage valid bits; only pixels enter the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid && cmd;
      end
      for (int s = 2; s <= L; s++) begin
        if (rdy[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  assign out_valid = vld[L];

  // table addressing and range checks
  assign tidx_ext = RAW_W'(table_index);
  assign tidx_ok  = (tidx_ext < RAW_W'(TABLE_ENTRIES));
  assign raw_ok   = (raw_depth < RAW_W'(TABLE_ENTRIES));

  dtid_table #(
    .ENTRIES (TABLE_ENTRIES),
    .DATA_W  (TABLE_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (load_acc && tidx_ok),
    .wr_addr (tidx_ext[AW-1:0]),
    .wr_data (table_value),
    .rd_en   (pix_acc && raw_ok),
    .rd_addr (raw_depth[AW-1:0]),
    .rd_data (tword)
  );

  // accept stage: flags and pixel offsets from the principal point
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_raw_ok          <= raw_ok;
      s1_side.no_reading <= (raw_depth >= NO_READING_CODE);
      s1_side.diff_u     <= $signed({2'b00, col, 4'b0000}) - $signed({1'b0, centre_x});
      s1_side.diff_v     <= $signed({2'b00, row, 4'b0000}) - $signed({1'b0, centre_y});
    end
  end

  dtid_recip u_recip (
    .clk      (clk),
    .en       (rdy[RECIP_STAGES+1:2]),
    .tword    (tword),
    .tword_ok (s1_raw_ok),
    .side_in  (s1_side),
    .res      (recip_res)
  );

  dtid_norm u_norm (
    .clk           (clk),
    .en            (rdy[L:L-1]),
    .focal_x_recip (focal_x_recip),
    .focal_y_recip (focal_y_recip),
    .res_in        (recip_res),
    .u_coord       (u_coord),
    .v_coord       (v_coord),
    .inv_depth     (inv_depth),
    .valid_res     (valid_res)
  );

  // a result with no reading carries the marker in every field
  a_invalid_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |->
      u_coord == INVALID_Q20 && v_coord == INVALID_Q20 && inv_depth == INVALID_Q20)
    else $error("no-reading result without marker values");

  // inverse depth of a real reading is never negative
  a_inv_positive: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> !inv_depth[RES_W-1])
    else $error("negative inverse depth");

  // input is only refused when the output is backed up
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused while pipeline can advance");

  // an accepted pixel is in the first stage on the next cycle
  a_pixel_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd |=> vld[1])
    else $error("accepted pixel lost at entry");

endmodule

`default_nettype wire

@@ bench/depth_to_inverse_depth_cloud_unit_tb.sv @@
// self-checking testbench for the depth to inverse depth cloud unit
// depends on dtid_pkg and depth_to_inverse_depth_cloud_unit
`timescale 1ns / 100ps

module depth_to_inverse_depth_cloud_unit_tb;
  import dtid_pkg::*;

  localparam int TABLE_ENTRIES = 2047;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE        = PIPE_STAGES + 8;
  localparam int BATCH         = 120;
  localparam longint SAT_HI    = 64'sd2147483647;
  localparam longint SAT_LO    = -64'sd2147483648;

  // register values after reset
  localparam logic [RECIP_W-1:0]  RESET_RECIP    = 24'd28926;
  localparam logic [CENTRE_W-1:0] RESET_CENTRE_X = 16'd5120;
  localparam logic [CENTRE_W-1:0] RESET_CENTRE_Y = 16'd3840;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  typedef struct {
    cmd_t               op;
    logic [RAW_W-1:0]   raw;
    logic [PIX_W-1:0]   row;
    logic [PIX_W-1:0]   col;
    logic [PIX_W-1:0]   tidx;
    logic [TABLE_W-1:0] tval;
  } depth_req_t;

  typedef struct {
    logic signed [RES_W-1:0] u;
    logic signed [RES_W-1:0] v;
    logic signed [RES_W-1:0] q;
    logic                    ok;
  } point_t;

  // mirror of the unit's table and registers, plus the points still owed
  class point_ledger;
    logic [RECIP_W-1:0]  recip_u;
    logic [RECIP_W-1:0]  recip_v;
    logic [CENTRE_W-1:0] centre_u;
    logic [CENTRE_W-1:0] centre_v;
    logic [TABLE_W-1:0]  depth_words [TABLE_ENTRIES];
    point_t              pending_points [$];
    int                  failures;

    function new();
      recip_u  = RESET_RECIP;
      recip_v  = RESET_RECIP;
      centre_u = RESET_CENTRE_X;
      centre_v = RESET_CENTRE_Y;
      failures = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FOCAL_X_RECIP: recip_u  = data;
        REG_FOCAL_Y_RECIP: recip_v  = data;
        REG_CENTRE_X:      centre_u = data[CENTRE_W-1:0];
        REG_CENTRE_Y:      centre_v = data[CENTRE_W-1:0];
        default: ;
      endcase
    endfunction

    // (pix*16 - centre) * recip in Q.28, rounded half up to Q.20, saturated
    function logic signed [RES_W-1:0] offset_scale(logic [PIX_W-1:0] pix,
                                                   logic [CENTRE_W-1:0] centre,
                                                   logic [RECIP_W-1:0] recip);
      longint acc;
      acc = (longint'(pix) * 16 - longint'(centre)) * longint'(recip) + 128;
      acc = acc >>> 8;
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      return acc[RES_W-1:0];
    endfunction

    // round(2^36 / t), saturating on a zero or tiny word
    function logic signed [RES_W-1:0] inverse_depth(logic [TABLE_W-1:0] word);
      longint t;
      longint qq;
      t = longint'(word);
      if (t == 0) return SAT_HI[RES_W-1:0];
      qq = ((longint'(1) <<< 36) + (t >>> 1)) / t;
      if (qq > SAT_HI) qq = SAT_HI;
      return qq[RES_W-1:0];
    endfunction

    function void take_item(depth_req_t it);
      point_t p;
      logic [TABLE_W-1:0] word;
      if (it.op == CMD_LOAD) begin
        if (int'(it.tidx) < TABLE_ENTRIES) depth_words[it.tidx] = it.tval;
        return;
      end
      if (it.raw >= NO_READING_CODE) begin
        p.u  = INVALID_Q20;
        p.v  = INVALID_Q20;
        p.q  = INVALID_Q20;
        p.ok = 1'b0;
      end else begin
        word = (int'(it.raw) < TABLE_ENTRIES) ? depth_words[it.raw] : '0;
        p.u  = offset_scale(it.col, centre_u, recip_u);
        p.v  = offset_scale(it.row, centre_v, recip_v);
        p.q  = inverse_depth(word);
        p.ok = 1'b1;
      end
      pending_points = {pending_points, p};
    endfunction

    function void match(string name, logic signed [RES_W-1:0] want,
                        logic signed [RES_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected result, expected none actual u %0d v %0d q %0d",
                 $time, got.u, got.v, got.q);
        failures++;
        return;
      end
      want = pending_points.pop_front();
      match("u_coord", want.u, got.u);
      match("v_coord", want.v, got.v);
      match("inv_depth", want.q, got.q);
      if (got.ok !== want.ok) begin
        $display("%0t: valid_res mismatch, expected %0b actual %0b", $time, want.ok, got.ok);
        failures++;
      end
    endfunction

    function int outstanding();
      return pending_points.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic                    cmd;
  logic [RAW_W-1:0]        raw_depth;
  logic [PIX_W-1:0]        row;
  logic [PIX_W-1:0]        col;
  logic [PIX_W-1:0]        table_index;
  logic [TABLE_W-1:0]      table_value;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [RES_W-1:0] u_coord;
  logic signed [RES_W-1:0] v_coord;
  logic signed [RES_W-1:0] inv_depth;
  logic                    valid_res;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  point_ledger ledger;
  bit          brisk;
  bit          loaded [TABLE_ENTRIES];
  int          loaded_list [$];
  int          quiet_cycles = 0;

  depth_to_inverse_depth_cloud_unit uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .raw_depth   (raw_depth),
    .row         (row),
    .col         (col),
    .table_index (table_index),
    .table_value (table_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .u_coord     (u_coord),
    .v_coord     (v_coord),
    .inv_depth   (inv_depth),
    .valid_res   (valid_res),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #6 clk = ~clk;

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic depth_req_t make_load(int idx, logic [TABLE_W-1:0] val);
    depth_req_t it;
    it.op   = CMD_LOAD;
    it.raw  = RAW_W'($urandom);
    it.row  = PIX_W'($urandom);
    it.col  = PIX_W'($urandom);
    it.tidx = PIX_W'(idx);
    it.tval = val;
    if (idx < TABLE_ENTRIES && !loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list = {loaded_list, idx};
    end
    return it;
  endfunction

  function automatic depth_req_t make_pixel(int raw, int r, int c);
    depth_req_t it;
    it.op   = CMD_PIXEL;
    it.raw  = RAW_W'(raw);
    it.row  = PIX_W'(r);
    it.col  = PIX_W'(c);
    it.tidx = PIX_W'($urandom);
    it.tval = TABLE_W'($urandom);
    return it;
  endfunction

  // mostly pixels on loaded entries, some loads, some with no reading
  function automatic depth_req_t random_item();
    int pick;
    int idx;
    logic [TABLE_W-1:0] val;
    pick = $urandom_range(0, 7);
    if (pick < 2) begin
      idx = ($urandom_range(0, 39) == 0) ? TABLE_ENTRIES : $urandom_range(0, TABLE_ENTRIES - 1);
      case ($urandom_range(0, 7))
        0:       val = '0;
        1:       val = TABLE_W'($urandom_range(1, 40));
        2:       val = '1;
        default: val = TABLE_W'($urandom);
      endcase
      return make_load(idx, val);
    end
    if (pick == 2 || loaded_list.size() == 0)
      return make_pixel($urandom_range(NO_READING_CODE, 16'hffff), $urandom, $urandom);
    return make_pixel(loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                      $urandom, $urandom);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_item(depth_req_t it);
    int gap;
    gap = brisk ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd         = it.op;
    raw_depth   = it.raw;
    row         = it.row;
    col         = it.col;
    table_index = it.tidx;
    table_value = it.tval;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    ledger.take_item(it);
    @(negedge clk);
  endtask

  // lower valid and wait until every owed point has come back
  task automatic hold_input();
    in_valid = 1'b0;
    while (ledger.outstanding() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    ledger.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(logic [RECIP_W-1:0] rx, logic [RECIP_W-1:0] ry,
                               logic [CENTRE_W-1:0] cx, logic [CENTRE_W-1:0] cy);
    hold_input();
    repeat (SETTLE) @(negedge clk);
    write_reg(REG_FOCAL_X_RECIP, rx);
    write_reg(REG_FOCAL_Y_RECIP, ry);
    write_reg(REG_CENTRE_X, CFG_DATA_W'(cx));
    write_reg(REG_CENTRE_Y, CFG_DATA_W'(cy));
  endtask

  // random batch with one full drain and one stretch without idling
  task automatic run_batch(int count);
    int pause_at;
    int calm_from;
    pause_at  = $urandom_range(10, count - 10);
    calm_from = $urandom_range(0, count - 30);
    for (int n = 0; n < count; n++) begin
      brisk = (n >= calm_from) && (n < calm_from + 25);
      if (n == pause_at) hold_input();
      push_item(random_item());
    end
    brisk = 1'b0;
  endtask

  // result side: random stalls, checks every transaction
  task automatic drain_results();
    int stall;
    point_t got;
    forever begin
      stall = brisk ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      got.u  = u_coord;
      got.v  = v_coord;
      got.q  = inv_depth;
      got.ok = valid_res;
      ledger.check_point(got);
      @(negedge clk);
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    cmd         = CMD_LOAD;
    raw_depth   = '0;
    row         = '0;
    col         = '0;
    table_index = '0;
    table_value = '0;
    out_ready   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_FOCAL_X_RECIP;
    cfg_data    = '0;
    brisk       = 1'b0;
    ledger      = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    fork
      drain_results();
    join_none

    // directed: table word extremes, ignored load, pixel corners, no reading
    push_item(make_load(0, 24'd0));
    push_item(make_load(1, 24'd1));
    push_item(make_load(5, 24'd31));
    push_item(make_load(6, 24'd32));
    push_item(make_load(1024, 24'h010000));
    push_item(make_load(1365, 24'haaaaaa));
    push_item(make_load(682, 24'h555555));
    push_item(make_load(2046, 24'hffffff));
    push_item(make_load(TABLE_ENTRIES, 24'h123456));
    push_item(make_pixel(0, 0, 0));
    push_item(make_pixel(1, 2047, 2047));
    push_item(make_pixel(5, 240, 320));
    push_item(make_pixel(6, 0, 2047));
    push_item(make_pixel(1024, 2047, 0));
    push_item(make_pixel(1365, 11'h555, 11'h2aa));
    push_item(make_pixel(682, 11'h2aa, 11'h555));
    push_item(make_pixel(2046, 1023, 1024));
    push_item(make_pixel(NO_READING_CODE, 100, 100));
    push_item(make_pixel(16'hffff, 2047, 2047));
    push_item(make_pixel(16'h8000, 0, 0));
    run_batch(BATCH);

    // register extremes, then random and typical settings
    apply_setting(24'd0, 24'd0, 16'd0, 16'd0);
    run_batch(BATCH);
    apply_setting(24'hffffff, 24'hffffff, 16'hffff, 16'hffff);
    run_batch(BATCH);
    apply_setting(24'hffffff, 24'hffffff, 16'd0, 16'd0);
    run_batch(BATCH);
    apply_setting(RECIP_W'($urandom), RECIP_W'($urandom),
                  CENTRE_W'($urandom), CENTRE_W'($urandom));
    run_batch(BATCH);
    apply_setting(RECIP_W'($urandom_range(20000, 40000)),
                  RECIP_W'($urandom_range(20000, 40000)),
                  CENTRE_W'($urandom_range(4000, 6000)),
                  CENTRE_W'($urandom_range(3000, 5000)));
    run_batch(BATCH);
    apply_setting(RESET_RECIP, RESET_RECIP, RESET_CENTRE_X, RESET_CENTRE_Y);
    run_batch(BATCH);

    // let the pipeline empty before the verdict
    hold_input();
    repeat (SETTLE) @(negedge clk);
    if (ledger.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
